>>> rtl/core/scd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream credit dispatcher package
// Shared constants, item structs and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package scd_pkg;

    localparam int STREAMS     = 8;
    localparam int SID_W       = 3;
    localparam int QUEUE_DEPTH = 64;
    localparam int QPTR_W      = 6;
    localparam int FILL_W      = 7;
    localparam int TAG_BITS    = 32;
    localparam int CAP_W       = 14;
    localparam int TOTAL_W     = 10;
    localparam int LIVE_W      = 4;
    localparam int MINCAP_W    = 11;
    localparam int MEM_DEPTH   = STREAMS * QUEUE_DEPTH;
    localparam int MEM_AW      = SID_W + QPTR_W;
    localparam int PADDR_W     = 3;

    localparam logic [CAP_W-1:0]    CAP_MAX    = {CAP_W{1'b1}};
    localparam logic [MINCAP_W-1:0] MINCAP_RST = 11'd16;
    localparam logic [CAP_W-1:0]    LIMIT_RST  =
        CAP_W'((16 + STREAMS / 2) / STREAMS);
    localparam logic [CAP_W-1:0]    WIN_RST    = CAP_W'(16);

    // divider for the fair-share average
    localparam int DIV_NUM_W = 16;
    localparam int DIV_DEN_W = 5;
    localparam int DIV_CNT_W = 4;

    // sort sequencer
    localparam logic [SID_W-1:0] SORT_LAST = SID_W'(STREAMS - 2);

    // command codes
    localparam logic [1:0] CMD_ENQ  = 2'd0;
    localparam logic [1:0] CMD_DISP = 2'd1;
    localparam logic [1:0] CMD_CPL  = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_DISP = 2'd1;
    localparam logic [1:0] STAT_NONE = 2'd2;
    localparam logic [1:0] STAT_DROP = 2'd3;

    // register index
    localparam logic REG_MIN_CAPACITY = 1'b0;

    typedef struct packed {
        logic [1:0]          command;
        logic [SID_W-1:0]    stream_sel;
        logic [TAG_BITS-1:0] transaction_tag;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [SID_W-1:0]    out_stream;
        logic [TAG_BITS-1:0] out_tag;
        logic                rebalanced;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic rb_init;
        logic sort_step;
        logic sort_key_limit;
        logic div_start;
        logic spread;
        logic peel_begin;
        logic peel_hi;
        logic peel_lo;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic need_reb;
        logic sort_done;
        logic div_done;
        logic dec_spread;
        logic dec_peel_hi;
        logic peel_more_hi;
        logic peel_more_lo;
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/core/scd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix-2 restoring divider
// One quotient bit per cycle while busy; done pulses as the last bit is registered.
// ----------------------------------------------------------------------------
module scd_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [scd_pkg::DIV_NUM_W-1:0]  num,
    input  logic [scd_pkg::DIV_DEN_W-1:0]  den,
    output logic                           busy,
    output logic                           done,
    output logic [scd_pkg::DIV_NUM_W-1:0]  quot
);
    import scd_pkg::*;

    logic [DIV_NUM_W-1:0] q_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 ge;

    assign rem_sh = {rem_reg, q_reg[DIV_NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !start && cnt_reg == {DIV_CNT_W{1'b1}};
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == {DIV_CNT_W{1'b1}}) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[DIV_NUM_W-2:0], ge};
            rem_reg <= ge ? DIV_DEN_W'(rem_sh - {1'b0, den_reg})
                          : DIV_DEN_W'(rem_sh);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;

endmodule

>>> rtl/core/scd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream credit dispatcher datapath
// Queues, credit counters, rebalance registers, sorter and output register.
// ----------------------------------------------------------------------------
module scd_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [scd_pkg::MINCAP_W-1:0]    cfg_wdata,
    output logic [scd_pkg::MINCAP_W-1:0]    min_cap,
    input  scd_pkg::in_item_t               s_item,
    input  scd_pkg::dp_cmd_t                cmd,
    output scd_pkg::dp_stat_t               stat,
    output logic                            m_valid,
    input  logic                            m_ready,
    output scd_pkg::out_item_t              m_item
);
    import scd_pkg::*;

    logic [TAG_BITS-1:0] tag_mem [MEM_DEPTH];

    in_item_t            in_reg;
    logic [QPTR_W-1:0]   head_reg  [STREAMS];
    logic [FILL_W-1:0]   fill_reg  [STREAMS];
    logic [CAP_W-1:0]    infl_reg  [STREAMS];
    logic [CAP_W-1:0]    limit_reg [STREAMS];
    logic [SID_W-1:0]    rank_reg  [STREAMS];
    logic [CAP_W-1:0]    cc_reg;
    logic [CAP_W-1:0]    win_reg;
    logic [MINCAP_W-1:0] mincap_reg;
    logic [1:0]          res_status_reg;
    logic [SID_W-1:0]    res_stream_reg;
    logic                res_reb_reg;
    logic                res_hit_reg;
    logic [TAG_BITS-1:0] rd_data_reg;
    logic [SID_W-1:0]    sj_reg;
    logic [SID_W-1:0]    spass_reg;
    logic [SID_W-1:0]    lo_reg;
    logic [SID_W-1:0]    hi_reg;
    logic [SID_W-1:0]    idx_reg;
    logic [CAP_W-1:0]    left_reg;
    logic [TOTAL_W-1:0]  lbuf_reg;
    logic                m_valid_reg;
    out_item_t           m_item_reg;

    // dispatch search
    logic                hit;
    logic [SID_W-1:0]    sel;
    logic                enq_ok;
    logic                disp_go;
    logic [QPTR_W-1:0]   enq_pos;
    logic [CAP_W-1:0]    cc_inc;
    logic                trig;
    logic [CAP_W-1:0]    limit_init;

    // rebalance
    logic [TOTAL_W-1:0]  total_c;
    logic [LIVE_W-1:0]   live_c;
    logic [FILL_W-1:0]   minsz_c;
    logic [CAP_W-1:0]    base_c;
    logic [CAP_W-1:0]    want_c;
    logic [CAP_W-1:0]    cap_c;
    logic [CAP_W-1:0]    key_a;
    logic [CAP_W-1:0]    key_b;
    logic [SID_W-1:0]    rk_a;
    logic [SID_W-1:0]    rk_b;
    logic [DIV_CNT_W-1:0] cnt_c;
    logic [DIV_NUM_W-1:0] quot;
    logic                div_busy;
    logic                div_done;
    logic [CAP_W-1:0]    avg;
    logic [CAP_W-1:0]    f_lo;
    logic [CAP_W-1:0]    f_hi;
    logic [CAP_W-1:0]    f_idx;
    logic                more_hi;
    logic                more_lo;

    assign limit_init = CAP_W'((12'(cfg_wdata) + 12'd4) >> 3);

    always_comb begin
        hit = 1'b0;
        sel = '0;
        for (int i = 0; i < STREAMS; i++) begin
            if (!hit && fill_reg[rank_reg[i]] != '0 &&
                infl_reg[rank_reg[i]] < limit_reg[rank_reg[i]]) begin
                hit = 1'b1;
                sel = rank_reg[i];
            end
        end
    end

    assign enq_ok  = cmd.exec && in_reg.command == CMD_ENQ &&
                     fill_reg[in_reg.stream_sel] < FILL_W'(QUEUE_DEPTH);
    assign disp_go = cmd.exec && in_reg.command == CMD_DISP && hit;
    assign enq_pos = head_reg[in_reg.stream_sel] +
                     QPTR_W'(fill_reg[in_reg.stream_sel]);
    assign cc_inc  = (cc_reg < CAP_MAX) ? cc_reg + 1'b1 : cc_reg;
    assign trig    = cc_inc >= win_reg;

    always_comb begin
        total_c = '0;
        live_c  = '0;
        minsz_c = '0;
        for (int k = 0; k < STREAMS; k++) begin
            if (fill_reg[k] != '0) begin
                if (live_c == '0 || fill_reg[k] < minsz_c) minsz_c = fill_reg[k];
                total_c = total_c + TOTAL_W'(fill_reg[k]);
                live_c  = live_c + 1'b1;
            end
        end
        base_c = {mincap_reg, 3'b000};
        want_c = CAP_W'({minsz_c, 3'b000});
        if (want_c < CAP_W'(mincap_reg)) want_c = CAP_W'(mincap_reg);
        if (live_c == '0)
            cap_c = base_c;
        else if (live_c == LIVE_W'(1))
            cap_c = (CAP_W'(total_c) > base_c) ? CAP_W'(total_c) : base_c;
        else
            cap_c = (want_c < base_c) ? want_c : base_c;
    end

    // sorter: one adjacent compare-and-swap per cycle while sort_step is set
    assign rk_a  = rank_reg[sj_reg];
    assign rk_b  = rank_reg[SID_W'(sj_reg + 1'b1)];
    assign key_a = cmd.sort_key_limit ? limit_reg[rk_a] : CAP_W'(fill_reg[rk_a]);
    assign key_b = cmd.sort_key_limit ? limit_reg[rk_b] : CAP_W'(fill_reg[rk_b]);

    assign cnt_c = DIV_CNT_W'(hi_reg - lo_reg) + 1'b1;
    assign avg   = quot[CAP_W-1:0];
    assign f_lo  = CAP_W'(fill_reg[rank_reg[lo_reg]]);
    assign f_hi  = CAP_W'(fill_reg[rank_reg[hi_reg]]);
    assign f_idx = CAP_W'(fill_reg[rank_reg[idx_reg]]);
    assign more_hi = idx_reg > lo_reg && f_idx >= avg;
    assign more_lo = idx_reg < hi_reg && f_idx <= avg;

    scd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     ({1'b0, left_reg, 1'b0} + DIV_NUM_W'(cnt_c)),
        .den     ({cnt_c, 1'b0}),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (quot)
    );

    always_ff @(posedge aclk) begin
        if (cmd.accept) in_reg <= s_item;
    end

    always_ff @(posedge aclk) begin
        if (enq_ok) tag_mem[{in_reg.stream_sel, enq_pos}] <= in_reg.transaction_tag;
        if (disp_go) rd_data_reg <= tag_mem[{sel, head_reg[sel]}];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < STREAMS; k++) begin
                head_reg[k]  <= '0;
                fill_reg[k]  <= '0;
                infl_reg[k]  <= '0;
                limit_reg[k] <= LIMIT_RST;
                rank_reg[k]  <= SID_W'(k);
            end
            cc_reg      <= '0;
            win_reg     <= WIN_RST;
            mincap_reg  <= MINCAP_RST;
            res_reb_reg <= 1'b0;
            res_hit_reg <= 1'b0;
            sj_reg      <= '0;
            spass_reg   <= '0;
            lo_reg      <= '0;
            hi_reg      <= SID_W'(STREAMS - 1);
            idx_reg     <= '0;
        end else begin
            if (cfg_we) begin
                mincap_reg <= cfg_wdata;
                for (int k = 0; k < STREAMS; k++) begin
                    infl_reg[k]  <= '0;
                    limit_reg[k] <= limit_init;
                    rank_reg[k]  <= SID_W'(k);
                end
                cc_reg  <= '0;
                win_reg <= CAP_W'(cfg_wdata);
            end
            if (cmd.exec) begin
                res_reb_reg    <= in_reg.command == CMD_CPL && trig;
                res_hit_reg    <= disp_go;
                res_stream_reg <= disp_go ? sel : in_reg.stream_sel;
                case (in_reg.command)
                    CMD_ENQ: begin
                        if (enq_ok) begin
                            fill_reg[in_reg.stream_sel] <= fill_reg[in_reg.stream_sel] + 1'b1;
                            res_status_reg <= STAT_OK;
                        end else begin
                            res_status_reg <= STAT_DROP;
                        end
                    end
                    CMD_DISP: begin
                        if (hit) begin
                            head_reg[sel]  <= head_reg[sel] + 1'b1;
                            fill_reg[sel]  <= fill_reg[sel] - 1'b1;
                            infl_reg[sel]  <= infl_reg[sel] + 1'b1;
                            res_status_reg <= STAT_DISP;
                        end else begin
                            res_status_reg <= STAT_NONE;
                        end
                    end
                    CMD_CPL: begin
                        res_status_reg <= STAT_OK;
                        if (infl_reg[in_reg.stream_sel] != '0)
                            infl_reg[in_reg.stream_sel] <= infl_reg[in_reg.stream_sel] - 1'b1;
                        cc_reg <= trig ? '0 : cc_inc;
                    end
                    default: begin
                        res_status_reg <= STAT_NONE;
                    end
                endcase
            end
            if (cmd.rb_init) begin
                for (int k = 0; k < STREAMS; k++) rank_reg[k] <= SID_W'(k);
                win_reg   <= cap_c;
                left_reg  <= cap_c;
                lbuf_reg  <= total_c;
                lo_reg    <= '0;
                hi_reg    <= SID_W'(STREAMS - 1);
                sj_reg    <= '0;
                spass_reg <= '0;
            end
            if (cmd.sort_step) begin
                if (key_a > key_b) begin
                    rank_reg[sj_reg]                  <= rk_b;
                    rank_reg[SID_W'(sj_reg + 1'b1)]   <= rk_a;
                end
                if (sj_reg == SORT_LAST) begin
                    sj_reg    <= '0;
                    spass_reg <= (spass_reg == SORT_LAST) ? '0 : spass_reg + 1'b1;
                end else begin
                    sj_reg <= sj_reg + 1'b1;
                end
            end
            if (cmd.spread) begin
                for (int k = 0; k < STREAMS; k++) begin
                    if (SID_W'(k) >= lo_reg && SID_W'(k) <= hi_reg)
                        limit_reg[rank_reg[k]] <= avg;
                end
            end
            if (cmd.peel_begin) idx_reg <= (lbuf_reg <= TOTAL_W'(0) ||
                CAP_W'(lbuf_reg) <= left_reg) ? hi_reg : lo_reg;
            if (cmd.peel_hi || cmd.peel_lo) begin
                if ((cmd.peel_hi && more_hi) || (cmd.peel_lo && more_lo)) begin
                    limit_reg[rank_reg[idx_reg]] <= f_idx;
                    left_reg <= (left_reg > f_idx) ? left_reg - f_idx : '0;
                    lbuf_reg <= (CAP_W'(lbuf_reg) > f_idx) ?
                                TOTAL_W'(CAP_W'(lbuf_reg) - f_idx) : '0;
                    idx_reg  <= cmd.peel_hi ? idx_reg - 1'b1 : idx_reg + 1'b1;
                end else if (cmd.peel_hi) begin
                    hi_reg <= idx_reg;
                end else begin
                    lo_reg <= idx_reg;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_item_reg.status     <= res_status_reg;
            m_item_reg.out_stream <= res_stream_reg;
            m_item_reg.out_tag    <= res_hit_reg ? rd_data_reg : '0;
            m_item_reg.rebalanced <= res_reb_reg;
        end
    end

    assign stat.need_reb     = res_reb_reg;
    assign stat.sort_done    = sj_reg == SORT_LAST && spass_reg == SORT_LAST;
    assign stat.div_done     = div_done;
    assign stat.dec_spread   = f_lo >= avg || f_hi <= avg;
    assign stat.dec_peel_hi  = CAP_W'(lbuf_reg) <= left_reg;
    assign stat.peel_more_hi = more_hi;
    assign stat.peel_more_lo = more_lo;
    assign stat.out_free     = !m_valid_reg || m_ready;

    assign min_cap = mincap_reg;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("output register loaded while occupied");
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");
    a_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        lo_reg <= hi_reg)
        else $error("fair-share window inverted");
    a_hit_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        res_hit_reg |-> res_status_reg == STAT_DISP)
        else $error("dispatched tag without dispatch status");

endmodule

>>> rtl/core/scd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream credit dispatcher controller
// Sequences item execution, the rebalance walk and the result hand-off.
// ----------------------------------------------------------------------------
module scd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  scd_pkg::dp_stat_t  stat,
    output scd_pkg::dp_cmd_t   cmd
);
    import scd_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_EXEC      = 12'b0000_0000_0010,
        S_POST      = 12'b0000_0000_0100,
        S_RB_INIT   = 12'b0000_0000_1000,
        S_SORT_FILL = 12'b0000_0001_0000,
        S_DIV_START = 12'b0000_0010_0000,
        S_DIV_WAIT  = 12'b0000_0100_0000,
        S_DECIDE    = 12'b0000_1000_0000,
        S_PEEL_HI   = 12'b0001_0000_0000,
        S_PEEL_LO   = 12'b0010_0000_0000,
        S_SORT_LIM  = 12'b0100_0000_0000,
        S_RESULT    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                cmd.accept = s_valid;
                if (s_valid) state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_POST;
            end
            S_POST: begin
                state_next = stat.need_reb ? S_RB_INIT : S_RESULT;
            end
            S_RB_INIT: begin
                cmd.rb_init = 1'b1;
                state_next  = S_SORT_FILL;
            end
            S_SORT_FILL: begin
                cmd.sort_step = 1'b1;
                if (stat.sort_done) state_next = S_DIV_START;
            end
            S_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (stat.div_done) state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (stat.dec_spread) begin
                    cmd.spread = 1'b1;
                    state_next = S_SORT_LIM;
                end else begin
                    cmd.peel_begin = 1'b1;
                    state_next     = stat.dec_peel_hi ? S_PEEL_HI : S_PEEL_LO;
                end
            end
            S_PEEL_HI: begin
                cmd.peel_hi = 1'b1;
                if (!stat.peel_more_hi) state_next = S_DIV_START;
            end
            S_PEEL_LO: begin
                cmd.peel_lo = 1'b1;
                if (!stat.peel_more_lo) state_next = S_DIV_START;
            end
            S_SORT_LIM: begin
                cmd.sort_step      = 1'b1;
                cmd.sort_key_limit = 1'b1;
                if (stat.sort_done) state_next = S_RESULT;
            end
            S_RESULT: begin
                cmd.out_load = stat.out_free;
                if (stat.out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready = state_reg == S_IDLE;

endmodule

>>> rtl/core/stream_credit_dispatcher_core.sv
`timescale 1ns / 1ps
// Sequence: a result is offered once its item is accepted, executed (with the tag memory
//   read), post-checked and loaded into the output register; a completion that closes
//   the window adds the rebalance init, a fill-keyed sort, radix-2 divider passes for the
//   fair-share average, per peel pass one step per peeled stream plus one to close the
//   pass, and a limit-keyed sort. One item at a time is taken. Reset (aresetn
//   low, synchronous) empties all queues, clears counts, sets min_capacity 16, limits 2.
// ----------------------------------------------------------------------------
// Stream credit dispatcher
// Per-stream tag queues with credit-limited priority dispatch and periodic
// fair-share rebalancing of the per-stream limits.
// ----------------------------------------------------------------------------
module stream_credit_dispatcher_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // item input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  scd_pkg::in_item_t             s_item,
    // result output
    output logic                          m_valid,
    input  logic                          m_ready,
    output scd_pkg::out_item_t            m_item,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scd_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import scd_pkg::*;

    dp_cmd_t              cmd;
    dp_stat_t             stat;
    logic                 cfg_we;
    logic [MINCAP_W-1:0]  min_cap;

    // Write min_capacity in the access phase; writes to other words are dropped.
    assign cfg_we = psel && penable && pwrite && paddr[2] == REG_MIN_CAPACITY;
    assign pready = 1'b1;
    // Return the register for any read of word zero, zero elsewhere.
    assign prdata = (paddr[2] == REG_MIN_CAPACITY) ? {21'd0, min_cap} : 32'd0;

    // Controller: owns the sequence, never touches payload.
    scd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: queues, counters, rebalance arithmetic and the output register.
    scd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (pwdata[MINCAP_W-1:0]),
        .min_cap   (min_cap),
        .s_item    (s_item),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
